FILE: sv/polled_motor_link_master_top_assert.svh
// Assertion macros shared by the link master modules.
// Needs nothing else; define ASSERT_OFF to compile the checks out.
`ifndef POLLED_MOTOR_LINK_MASTER_TOP_ASSERT_SVH
`define POLLED_MOTOR_LINK_MASTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold on every clock edge outside reset.
`define PMLM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pmlm assertion failed");
// Expression must never be true outside reset.
`define PMLM_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pmlm forbidden condition");
`else
`define PMLM_ASSERT(lbl, clk, rst, prop)
`define PMLM_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

FILE: sv/pmlm_pkg.sv
// Shared types and constants of the polled motor link master.
// No dependencies.
package pmlm_pkg;

   // Poll configuration
   localparam int NUM_DRIVERS  = 5;
   localparam int SLOT_W       = (NUM_DRIVERS > 1) ? $clog2(NUM_DRIVERS) : 1;
   localparam int SPEED_INPUTS = 5;

   // Port field widths
   localparam int ACTION_W       = 2;
   localparam int BYTE_W         = 8;
   localparam int SPEED_W        = 16;
   localparam int REPORT_SLOT_W  = 3;
   localparam int REPORT_SPEED_W = 18;

   // Link characters
   localparam logic [7:0] CH_OPEN    = 8'h3C;  // '<'
   localparam logic [7:0] CH_CLOSE   = 8'h3E;  // '>'
   localparam logic [7:0] CH_DATA    = 8'h64;  // 'd'
   localparam logic [7:0] CH_SET     = 8'h73;  // 's'
   localparam logic [7:0] CH_ONE     = 8'h31;  // '1'
   localparam logic [7:0] CH_ID_LAST = 8'(8'h31 + NUM_DRIVERS - 1);

   // Reply parser positions
   localparam logic [3:0] RX_START = 4'd0;
   localparam logic [3:0] RX_ID    = 4'd1;
   localparam logic [3:0] RX_KIND  = 4'd2;
   localparam logic [3:0] RX_DATA0 = 4'd3;
   localparam logic [3:0] RX_DATA3 = 4'd6;
   localparam logic [3:0] RX_END   = 4'd7;
   localparam logic [3:0] RX_FULL  = 4'd8;

   // Command frame positions
   localparam logic [2:0] POS_OPEN  = 3'd0;
   localparam logic [2:0] POS_ID    = 3'd1;
   localparam logic [2:0] POS_KIND  = 3'd2;
   localparam logic [2:0] POS_DATA0 = 3'd3;
   localparam logic [2:0] POS_CLOSE = 3'd7;

   // Reported speed scale: ((v >> 8) * 1000) >> 16
   localparam logic signed [10:0] RPT_SCALE = 11'sd1000;

   // Command payload: floor(|s| * 65536 / 1000) = (|s| * CMD_RECIP) >> 22,
   // exact for |s| <= 32768 (reciprocal error 7 / 2^35).
   localparam logic [28:0] CMD_RECIP       = 29'd274877907;
   localparam int          CMD_RECIP_SHIFT = 22;
   localparam int          CMD_MAG_W       = 22;

   // Job queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_BYTE = 2'd0,
      ACT_SET  = 2'd1,
      ACT_TICK = 2'd2
   } action_type;

   // One tick's work for the back end
   typedef struct packed {
      logic                             send;
      logic                             rep;
      logic                             done;
      logic [SLOT_W-1:0]                rep_slot;
      logic signed [REPORT_SPEED_W-1:0] rep_speed;
      logic [SLOT_W-1:0]                tx_slot;
      logic signed [SPEED_W-1:0]        speed;
   } job_type;

endpackage

FILE: sv/pmlm_queue.sv
// Short job queue between the front and back ends.
// Depends on pmlm_pkg.
`include "polled_motor_link_master_top_assert.svh"

module pmlm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pmlm_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              avail,
   output pmlm_pkg::job_type head_job
);
   import pmlm_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign avail    = (count_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `PMLM_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `PMLM_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `PMLM_ASSERT_NEVER(a_no_underflow, clock, reset, pop && !avail)

endmodule

FILE: sv/pmlm_front.sv
// Front end: reply parser, target speeds, poll sequencing and reply decode.
// Depends on pmlm_pkg; hands one job per productive tick to the queue.
module pmlm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pmlm_pkg::ACTION_W-1:0]         req_action,
   input  logic [pmlm_pkg::BYTE_W-1:0]           req_rx_byte,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]   req_speed_1,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]   req_speed_2,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]   req_speed_3,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]   req_speed_4,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]   req_speed_5,
   input  logic                                  queue_full,
   output logic                                  push,
   output pmlm_pkg::job_type                     push_job
);
   import pmlm_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_DRIVERS - 1);

   logic [3:0]              rx_count_ff, rx_count_in;
   logic [7:0]              rx_id_ff;
   logic [31:0]             rx_data_ff;
   logic [SLOT_W-1:0]       poll_ff, poll_in;
   logic                    round_ff, round_in;
   logic                    pend_ff, pend_in;
   logic signed [SPEED_W-1:0] target_ff [NUM_DRIVERS];
   logic signed [SPEED_W-1:0] speed_by_slot [SPEED_INPUTS];

   logic                    accept;
   logic                    set_en, id_we, data_we;
   logic [1:0]              data_lane;
   logic                    id_match, tick_rep, tick_done, tick_send;
   logic signed [23:0]      reply_val;
   logic signed [33:0]      reply_prod;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign data_lane = 2'(rx_count_ff - RX_DATA0);
   assign id_match  = (rx_id_ff == 8'(CH_ONE + 8'(poll_ff)));

   // Input speed fields by driver slot
   assign speed_by_slot[0] = req_speed_3;
   assign speed_by_slot[1] = req_speed_1;
   assign speed_by_slot[2] = req_speed_2;
   assign speed_by_slot[3] = req_speed_4;
   assign speed_by_slot[4] = req_speed_5;

   // Reply decode: floor((v >> 8) * 1000 / 65536)
   assign reply_val  = $signed(rx_data_ff[31:8]);
   assign reply_prod = 34'(reply_val) * 34'(RPT_SCALE);

   // Action decode, parser and poll sequencing
   always_comb begin
      rx_count_in = rx_count_ff;
      poll_in     = poll_ff;
      round_in    = round_ff;
      pend_in     = pend_ff;
      set_en      = 1'b0;
      id_we       = 1'b0;
      data_we     = 1'b0;
      tick_rep    = 1'b0;
      tick_done   = 1'b0;
      tick_send   = 1'b0;
      push        = 1'b0;
      if (accept) begin
         unique case (req_action)
            ACT_BYTE: begin
               unique case (rx_count_ff)
                  RX_START: rx_count_in = (req_rx_byte == CH_OPEN) ? RX_ID : RX_START;
                  RX_ID: begin
                     if (req_rx_byte >= CH_ONE && req_rx_byte <= CH_ID_LAST) begin
                        id_we       = 1'b1;
                        rx_count_in = RX_KIND;
                     end else begin
                        rx_count_in = RX_START;
                     end
                  end
                  RX_KIND: rx_count_in = (req_rx_byte == CH_DATA) ? RX_DATA0 : RX_START;
                  RX_END:  rx_count_in = (req_rx_byte == CH_CLOSE) ? RX_FULL : RX_START;
                  RX_FULL: rx_count_in = RX_FULL;
                  default: begin
                     data_we     = (rx_count_ff >= RX_DATA0) && (rx_count_ff <= RX_DATA3);
                     rx_count_in = 4'(rx_count_ff + 1'b1);
                  end
               endcase
            end
            ACT_SET: begin
               set_en   = 1'b1;
               round_in = 1'b1;
               pend_in  = 1'b1;
            end
            ACT_TICK: begin
               if (rx_count_ff == RX_FULL) begin
                  tick_rep    = id_match;
                  rx_count_in = RX_START;
                  if (id_match) begin
                     if (poll_ff == LAST_SLOT) begin
                        round_in = 1'b0;
                     end else begin
                        pend_in = 1'b1;
                     end
                  end
                  if (poll_ff == LAST_SLOT) begin
                     poll_in   = '0;
                     tick_done = 1'b1;
                  end else begin
                     poll_in = SLOT_W'(poll_ff + 1'b1);
                  end
               end
               tick_send = pend_in && round_in;
               pend_in   = 1'b0;
               push      = tick_send || tick_rep || tick_done;
            end
            default: ;
         endcase
      end
   end

   // Job handed to the back end
   always_comb begin
      push_job.send      = tick_send;
      push_job.rep       = tick_rep;
      push_job.done      = tick_done;
      push_job.rep_slot  = poll_ff;
      push_job.rep_speed = reply_prod[33:16];
      push_job.tx_slot   = poll_in;
      push_job.speed     = target_ff[poll_in];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff <= RX_START;
         poll_ff     <= '0;
         round_ff    <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         rx_count_ff <= rx_count_in;
         poll_ff     <= poll_in;
         round_ff    <= round_in;
         pend_ff     <= pend_in;
      end
   end

   // Reply holding registers
   always_ff @(posedge clock) begin
      if (id_we) begin
         rx_id_ff <= req_rx_byte;
      end
      if (data_we) begin
         rx_data_ff[8*data_lane +: 8] <= req_rx_byte;
      end
   end

   // Target speeds; slots without an input field stay zero
   for (genvar g = 0; g < NUM_DRIVERS; g++) begin : g_target
      always_ff @(posedge clock) begin
         if (reset) begin
            target_ff[g] <= '0;
         end else if (set_en && (g < SPEED_INPUTS)) begin
            target_ff[g] <= speed_by_slot[(g < SPEED_INPUTS) ? g : 0];
         end
      end
   end

endmodule

FILE: sv/pmlm_back.sv
// Back end: builds command payloads and serializes result transfers.
// Depends on pmlm_pkg; takes jobs from pmlm_queue.
`include "polled_motor_link_master_top_assert.svh"

module pmlm_back (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         job_avail,
   input  pmlm_pkg::job_type                            head_job,
   output logic                                         pop,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic                                         rsp_tx_valid,
   output logic [pmlm_pkg::BYTE_W-1:0]                  rsp_tx_byte,
   output logic                                         rsp_frame_end,
   output logic                                         rsp_report_valid,
   output logic [pmlm_pkg::REPORT_SLOT_W-1:0]           rsp_report_slot,
   output logic signed [pmlm_pkg::REPORT_SPEED_W-1:0]   rsp_report_speed,
   output logic                                         rsp_round_done
);
   import pmlm_pkg::*;

   logic                              act_ff, act_in;
   logic [2:0]                        cnt_ff, cnt_in;
   logic                              send_ff, rep_ff, done_ff;
   logic [SLOT_W-1:0]                 rep_slot_ff, tx_slot_ff;
   logic signed [REPORT_SPEED_W-1:0]  rep_speed_ff;
   logic [31:0]                       qword_ff;

   logic                              last, first, xfer;
   logic [SPEED_W-1:0]                cmd_abs;
   logic [44:0]                       cmd_prod;
   logic [31:0]                       cmd_mag, cmd_word;
   logic [1:0]                        q_lane;
   logic [7:0]                        frame_byte;

   assign xfer  = rsp_valid && rsp_ready;
   assign first = (cnt_ff == POS_OPEN);
   assign last  = send_ff ? (cnt_ff == POS_CLOSE) : 1'b1;
   assign pop   = job_avail && (!act_ff || (xfer && last));

   // Command payload: trunc(s * 65536 / 1000) * 256, two's complement
   assign cmd_abs  = head_job.speed[SPEED_W-1] ? SPEED_W'(-head_job.speed)
                                                : SPEED_W'(head_job.speed);
   assign cmd_prod = 45'(cmd_abs) * 45'(CMD_RECIP);
   assign cmd_mag  = {2'b00, cmd_prod[CMD_RECIP_SHIFT +: CMD_MAG_W], 8'h00};
   assign cmd_word = head_job.speed[SPEED_W-1] ? 32'(-cmd_mag) : cmd_mag;

   // Sequencer for the current job
   always_comb begin
      act_in = act_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         act_in = 1'b1;
         cnt_in = POS_OPEN;
      end else if (xfer) begin
         if (last) begin
            act_in = 1'b0;
            cnt_in = POS_OPEN;
         end else begin
            cnt_in = 3'(cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= POS_OPEN;
      end else begin
         act_ff <= act_in;
         cnt_ff <= cnt_in;
      end
   end

   // Job payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         send_ff      <= head_job.send;
         rep_ff       <= head_job.rep;
         done_ff      <= head_job.done;
         rep_slot_ff  <= head_job.rep_slot;
         rep_speed_ff <= head_job.rep_speed;
         tx_slot_ff   <= head_job.tx_slot;
         qword_ff     <= cmd_word;
      end
   end

   // Frame byte select
   assign q_lane = 2'(cnt_ff - POS_DATA0);
   always_comb begin
      case (cnt_ff)
         POS_OPEN:  frame_byte = CH_OPEN;
         POS_ID:    frame_byte = 8'(CH_ONE + 8'(tx_slot_ff));
         POS_KIND:  frame_byte = CH_SET;
         POS_CLOSE: frame_byte = CH_CLOSE;
         default:   frame_byte = qword_ff[8*q_lane +: 8];
      endcase
   end

   // Result transfer fields
   assign rsp_valid        = act_ff;
   assign rsp_tx_valid     = send_ff;
   assign rsp_tx_byte      = send_ff ? frame_byte : '0;
   assign rsp_frame_end    = last;
   assign rsp_report_valid = first && rep_ff;
   assign rsp_report_slot  = (first && rep_ff) ? REPORT_SLOT_W'(rep_slot_ff) : '0;
   assign rsp_report_speed = (first && rep_ff) ? rep_speed_ff : '0;
   assign rsp_round_done   = first && done_ff;

   `PMLM_ASSERT(a_idle_at_start, clock, reset, !act_ff |-> (cnt_ff == POS_OPEN))
   `PMLM_ASSERT(a_single_no_send, clock, reset, (act_ff && !send_ff) |-> (cnt_ff == POS_OPEN))
   `PMLM_ASSERT(a_frame_continues, clock, reset, (xfer && !last) |=> (act_ff && cnt_ff != POS_OPEN))

endmodule

FILE: sv/polled_motor_link_master_top.sv
// Top level of the polled motor link master.
// Depends on pmlm_pkg, pmlm_front, pmlm_queue and pmlm_back.
//
//   Channel  Handshake             Payload
//   req      req_valid/req_ready   action, rx_byte, speed_1..speed_5
//   rsp      rsp_valid/rsp_ready   tx_valid, tx_byte, frame_end, report_*, round_done
//
// One request transfer per cycle while the job queue (4 entries) has room.
// A productive tick gives one result transfer (report or round end only) or
// eight (command frame), one per cycle unless rsp_ready stalls; the back end's
// byte serializer sets the sustained rate when frames are sent back to back.
// Reset is synchronous; it clears the parser, poll state, targets and queue.
// A stalled rsp side holds the back end; the front keeps taking bytes, set
// actions and ticks until the queue is full.
module polled_motor_link_master_top (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [pmlm_pkg::ACTION_W-1:0]                req_action,
   input  logic [pmlm_pkg::BYTE_W-1:0]                  req_rx_byte,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_1,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_2,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_3,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_4,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_5,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic                                         rsp_tx_valid,
   output logic [pmlm_pkg::BYTE_W-1:0]                  rsp_tx_byte,
   output logic                                         rsp_frame_end,
   output logic                                         rsp_report_valid,
   output logic [pmlm_pkg::REPORT_SLOT_W-1:0]           rsp_report_slot,
   output logic signed [pmlm_pkg::REPORT_SPEED_W-1:0]   rsp_report_speed,
   output logic                                         rsp_round_done
);
   import pmlm_pkg::*;

   logic    push, queue_full, pop, job_avail;
   job_type push_job, head_job;

   pmlm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .req_speed_1 (req_speed_1),
      .req_speed_2 (req_speed_2),
      .req_speed_3 (req_speed_3),
      .req_speed_4 (req_speed_4),
      .req_speed_5 (req_speed_5),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   pmlm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .avail    (job_avail),
      .head_job (head_job)
   );

   pmlm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_avail        (job_avail),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tx_valid     (rsp_tx_valid),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_report_valid (rsp_report_valid),
      .rsp_report_slot  (rsp_report_slot),
      .rsp_report_speed (rsp_report_speed),
      .rsp_round_done   (rsp_round_done)
   );

endmodule

FILE: tb/pmlm_checker.sv
`timescale 1ns / 100ps
// Checker for the polled motor link master: follows every request transfer,
// predicts the response transfers it causes and compares them in order.
// Depends on pmlm_pkg.
module pmlm_checker (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   input  logic                                         req_ready,
   input  logic [pmlm_pkg::ACTION_W-1:0]                req_action,
   input  logic [pmlm_pkg::BYTE_W-1:0]                  req_rx_byte,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_1,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_2,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_3,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_4,
   input  logic signed [pmlm_pkg::SPEED_W-1:0]          req_speed_5,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   input  logic                                         rsp_tx_valid,
   input  logic [pmlm_pkg::BYTE_W-1:0]                  rsp_tx_byte,
   input  logic                                         rsp_frame_end,
   input  logic                                         rsp_report_valid,
   input  logic [pmlm_pkg::REPORT_SLOT_W-1:0]           rsp_report_slot,
   input  logic signed [pmlm_pkg::REPORT_SPEED_W-1:0]   rsp_report_speed,
   input  logic                                         rsp_round_done,
   output int                                           fail_count,
   output int                                           outstanding
);
   import pmlm_pkg::*;

   typedef struct {
      logic                             tx_valid;
      logic [BYTE_W-1:0]                tx_byte;
      logic                             frame_end;
      logic                             report_valid;
      logic [REPORT_SLOT_W-1:0]         report_slot;
      logic signed [REPORT_SPEED_W-1:0] report_speed;
      logic                             round_done;
   } link_result_type;

   // Mirror of the reply parser, poll state and targets
   logic [3:0]                reply_pos;
   logic [BYTE_W-1:0]         reply_id;
   logic [31:0]               reply_word;
   int                        poll_slot;
   bit                        round_on;
   bit                        frame_due;
   logic signed [SPEED_W-1:0] target_speed [NUM_DRIVERS];

   link_result_type link_results_q [$];

   // Measured speed: floor(((v >> 8) * 1000) / 65536) on the signed word
   function automatic logic signed [REPORT_SPEED_W-1:0] measured_speed(input logic [31:0] word);
      logic signed [23:0] upper;
      longint             prod;
      upper = word[31:8];
      prod  = longint'(upper) * 1000;
      return REPORT_SPEED_W'(prod >>> 16);
   endfunction

   // Command payload: (speed * 65536 / 1000, toward zero) * 256, low 32 bits
   function automatic logic [31:0] speed_command_word(input logic signed [SPEED_W-1:0] speed);
      longint q;
      q = (longint'(speed) * 65536) / 1000;
      return 32'(q * 256);
   endfunction

   task automatic take_reply_byte(input logic [BYTE_W-1:0] b);
      case (reply_pos)
         RX_START: reply_pos = (b == CH_OPEN) ? RX_ID : RX_START;
         RX_ID: begin
            // a bad id drops the frame; it never counts as a new start
            if (b >= CH_ONE && b <= CH_ID_LAST) begin
               reply_id  = b;
               reply_pos = RX_KIND;
            end else begin
               reply_pos = RX_START;
            end
         end
         RX_KIND: reply_pos = (b == CH_DATA) ? RX_DATA0 : RX_START;
         RX_END:  reply_pos = (b == CH_CLOSE) ? RX_FULL : RX_START;
         RX_FULL: ;  // frame waiting for a tick: byte dropped
         default: begin
            reply_word[8 * (reply_pos - RX_DATA0) +: 8] = b;
            reply_pos = reply_pos + 4'd1;
         end
      endcase
   endtask

   task automatic run_tick();
      bit                               rep;
      bit                               done;
      bit                               send;
      int                               rep_slot;
      logic signed [REPORT_SPEED_W-1:0] rep_speed;
      logic [BYTE_W-1:0]                frame [8];
      logic [31:0]                      qw;
      int                               n;
      int                               k;
      link_result_type                  r;
      rep       = 1'b0;
      done      = 1'b0;
      send      = 1'b0;
      rep_slot  = 0;
      rep_speed = '0;

      // Consume a waiting reply; wrong id still moves the poll on
      if (reply_pos == RX_FULL) begin
         if (reply_id == 8'(CH_ONE + poll_slot)) begin
            rep       = 1'b1;
            rep_slot  = poll_slot;
            rep_speed = measured_speed(reply_word);
            if (poll_slot == NUM_DRIVERS - 1) round_on = 1'b0;
            else frame_due = 1'b1;
         end
         poll_slot++;
         if (poll_slot >= NUM_DRIVERS) begin
            poll_slot = 0;
            done      = 1'b1;
         end
         reply_pos = RX_START;
      end

      // Next command frame
      if (frame_due) begin
         frame_due = 1'b0;
         if (round_on) begin
            qw               = speed_command_word(target_speed[poll_slot]);
            frame[POS_OPEN]  = CH_OPEN;
            frame[POS_ID]    = 8'(CH_ONE + poll_slot);
            frame[POS_KIND]  = CH_SET;
            for (k = 0; k < 4; k++) frame[POS_DATA0 + k] = qw[8 * k +: 8];
            frame[POS_CLOSE] = CH_CLOSE;
            send             = 1'b1;
         end
      end

      n = send ? 8 : ((rep || done) ? 1 : 0);
      for (k = 0; k < n; k++) begin
         r.tx_valid     = send;
         r.tx_byte      = send ? frame[k] : '0;
         r.frame_end    = (k == n - 1);
         r.report_valid = (k == 0) && rep;
         r.report_slot  = (k == 0 && rep) ? REPORT_SLOT_W'(rep_slot) : '0;
         r.report_speed = (k == 0 && rep) ? rep_speed : '0;
         r.round_done   = (k == 0) && done;
         link_results_q.push_back(r);
      end
   endtask

   task automatic compare_field(input string field, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // Requests are applied before responses so a same-edge result still lines up
   always @(posedge clock) begin
      link_result_type want;
      if (reset) begin
         reply_pos  = RX_START;
         reply_id   = '0;
         reply_word = '0;
         poll_slot  = 0;
         round_on   = 1'b0;
         frame_due  = 1'b0;
         foreach (target_speed[i]) target_speed[i] = '0;
         link_results_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            case (req_action)
               ACT_BYTE: take_reply_byte(req_rx_byte);
               ACT_SET: begin
                  // slot order of the speed inputs; slots past the pool are dropped
                  target_speed[1] = req_speed_1;
                  target_speed[2] = req_speed_2;
                  target_speed[0] = req_speed_3;
                  target_speed[3] = req_speed_4;
                  target_speed[4] = req_speed_5;
                  round_on  = 1'b1;
                  frame_due = 1'b1;
               end
               ACT_TICK: run_tick();
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (link_results_q.size() == 0) begin
               $display("%0t: response transfer with nothing expected, tx_byte %0h",
                        $time, rsp_tx_byte);
               fail_count++;
            end else begin
               want = link_results_q.pop_front();
               compare_field("tx_valid", want.tx_valid, rsp_tx_valid);
               compare_field("tx_byte", want.tx_byte, rsp_tx_byte);
               compare_field("frame_end", want.frame_end, rsp_frame_end);
               compare_field("report_valid", want.report_valid, rsp_report_valid);
               compare_field("report_slot", want.report_slot, rsp_report_slot);
               compare_field("report_speed", want.report_speed, rsp_report_speed);
               compare_field("round_done", want.round_done, rsp_round_done);
            end
         end
      end
      outstanding = link_results_q.size();
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the polled motor link master: clock, reset, request and
// response drivers, watchdog and verdict. Depends on pmlm_pkg, pmlm_checker, RTL.
module tb_top;
   import pmlm_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS  = 260;
   localparam int HOLD_AT      = 80;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 50;

   typedef logic [4:0][SPEED_W-1:0] speed_set_type;  // [0] is speed_1

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [ACTION_W-1:0]              req_action = ACT_BYTE;
   logic [BYTE_W-1:0]                req_rx_byte = '0;
   logic signed [SPEED_W-1:0]        req_speed_1 = '0;
   logic signed [SPEED_W-1:0]        req_speed_2 = '0;
   logic signed [SPEED_W-1:0]        req_speed_3 = '0;
   logic signed [SPEED_W-1:0]        req_speed_4 = '0;
   logic signed [SPEED_W-1:0]        req_speed_5 = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_tx_valid;
   logic [BYTE_W-1:0]                rsp_tx_byte;
   logic                             rsp_frame_end;
   logic                             rsp_report_valid;
   logic [REPORT_SLOT_W-1:0]         rsp_report_slot;
   logic signed [REPORT_SPEED_W-1:0] rsp_report_speed;
   logic                             rsp_round_done;

   int   fail_count;
   int   outstanding;
   int   items_sent = 0;
   int   idle_cycles = 0;
   bit   burst_mode = 1'b0;
   logic hold_request = 1'b0;

   polled_motor_link_master_top DUT (.*);
   pmlm_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [SPEED_W-1:0] rand_speed();
      if ($urandom_range(0, 3) != 0) return SPEED_W'($urandom());
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'h0001;
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      if ($urandom_range(0, 4) != 0) return $urandom();
      case ($urandom_range(0, 4))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         default: return 32'h0000_00FF;
      endcase
   endfunction

   function automatic speed_set_type rand_speeds();
      speed_set_type s;
      foreach (s[k]) s[k] = rand_speed();
      return s;
   endfunction

   // One request transfer; valid is only lowered when a gap comes before it
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                            input speed_set_type s, input bit counts);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_rx_byte <= b;
      req_speed_1 <= s[0];
      req_speed_2 <= s[1];
      req_speed_3 <= s[2];
      req_speed_4 <= s[3];
      req_speed_5 <= s[4];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (counts) items_sent++;
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      send_item(ACT_BYTE, b, rand_speeds(), 1'b1);
   endtask

   task automatic send_tick();
      send_item(ACT_TICK, BYTE_W'($urandom()), rand_speeds(), 1'b1);
   endtask

   task automatic send_reply(input logic [BYTE_W-1:0] id, input logic [31:0] word);
      int k;
      send_byte(CH_OPEN);
      send_byte(id);
      send_byte(CH_DATA);
      for (k = 0; k < 4; k++) send_byte(word[8 * k +: 8]);
      send_byte(CH_CLOSE);
   endtask

   // Request side: directed opening, then random poll traffic
   initial begin
      speed_set_type     s;
      int                poll_mirror;
      int                pick;
      int                k;
      bit                need_set;
      logic [BYTE_W-1:0] id;
      logic [BYTE_W-1:0] b;
      poll_mirror = 0;
      need_set    = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Tick with nothing waiting, unused action, second start byte as an id
      send_tick();
      send_item(ACT_UNUSED, BYTE_W'($urandom()), rand_speeds(), 1'b0);
      send_byte(CH_OPEN);
      send_byte(CH_OPEN);
      // Extreme targets, then the first two polls with extreme data words
      s[0] = 16'h7FFF;
      s[1] = 16'h8000;
      s[2] = 16'h0000;
      s[3] = 16'hFFFF;
      s[4] = 16'h0001;
      send_item(ACT_SET, BYTE_W'($urandom()), s, 1'b1);
      send_tick();
      send_reply(CH_ONE, 32'h7FFF_FFFF);
      send_item(ACT_BYTE, CH_OPEN, rand_speeds(), 1'b0);  // dropped while frame waits
      send_tick();
      send_reply(8'(CH_ONE + 1), 32'h8000_0000);
      send_tick();
      poll_mirror = 2;
      need_set    = 1'b0;

      while (items_sent < TOTAL_ITEMS) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         if (items_sent >= HOLD_AT) hold_request <= 1'b1;
         pick = $urandom_range(0, 99);
         if (need_set || pick < 8) begin
            send_item(ACT_SET, BYTE_W'($urandom()), rand_speeds(), 1'b1);
            need_set = 1'b0;
         end else if (pick < 72) begin
            // well-formed reply, mostly from the driver being polled
            if ($urandom_range(0, 4) == 0) id = 8'(CH_ONE + $urandom_range(0, NUM_DRIVERS - 1));
            else id = 8'(CH_ONE + poll_mirror);
            send_reply(id, rand_word());
            if ($urandom_range(0, 9) == 0)
               for (k = 0; k < $urandom_range(1, 2); k++)
                  send_item(ACT_BYTE, BYTE_W'($urandom()), rand_speeds(), 1'b0);
            send_tick();
            if (id != 8'(CH_ONE + poll_mirror) || poll_mirror == NUM_DRIVERS - 1)
               need_set = ($urandom_range(0, 3) != 0);
            poll_mirror = (poll_mirror + 1) % NUM_DRIVERS;
         end else if (pick < 80) begin
            send_tick();
         end else begin
            // broken sequences; each leaves the parser back at the start
            case ($urandom_range(0, 4))
               0: begin
                  send_byte(BYTE_W'($urandom()));
                  send_byte(8'h00);
               end
               1: begin
                  do b = BYTE_W'($urandom()); while (b >= CH_ONE && b <= CH_ID_LAST);
                  send_byte(CH_OPEN);
                  send_byte(b);
               end
               2: begin
                  do b = BYTE_W'($urandom()); while (b == CH_DATA);
                  send_byte(CH_OPEN);
                  send_byte(8'(CH_ONE + $urandom_range(0, NUM_DRIVERS - 1)));
                  send_byte(b);
               end
               3: begin
                  do b = BYTE_W'($urandom()); while (b == CH_CLOSE);
                  send_byte(CH_OPEN);
                  send_byte(8'(CH_ONE + $urandom_range(0, NUM_DRIVERS - 1)));
                  send_byte(CH_DATA);
                  for (k = 0; k < 4; k++) send_byte(BYTE_W'($urandom()));
                  send_byte(b);
               end
               default: send_item(ACT_UNUSED, BYTE_W'($urandom()), rand_speeds(), 1'b0);
            endcase
         end
      end
      req_valid <= 1'b0;

      // Drain at the falling edge so the checker's count is settled, then
      // allow trailing latency for stray results
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("polled_motor_link_master_top test passed");
      else $display("polled_motor_link_master_top test failed");
      $finish;
   end

   // Response side: random stalls, calm stretches, one long hold-off
   initial begin
      int stall_left;
      int calm_left;
      bit held;
      stall_left = 0;
      calm_left  = 0;
      held       = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request && !held) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 150);
            else stall_left = pick_gap();
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("polled_motor_link_master_top test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
